[design/arpr_pkg.sv]
// Shared constants and codes for the ARP resolver and responder.
// No dependencies; used by arp_resolver_and_responder_top.
package arpr_pkg;

    localparam int DEFAULT_CACHE_DEPTH = 8;

    localparam int IP_W      = 32;
    localparam int MAC_W     = 48;
    localparam int LEN_W     = 11;
    localparam int OP_W      = 16;
    localparam int TICK_W    = 6;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 144;
    localparam int M_DATA_W  = 80;

    localparam logic [CMD_W-1:0] CMD_RESOLVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PACKET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESOLVED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FAILED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [LEN_W-1:0]  ARP_MIN_LEN   = 11'd28;
    localparam logic [OP_W-1:0]   OP_REQUEST    = 16'd1;
    localparam logic [OP_W-1:0]   OP_REPLY      = 16'd2;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 6'd40;
    localparam logic [TICK_W-1:0] TICKS_MAX     = 6'd63;

endpackage

[design/arp_resolver_and_responder_top.sv]
// ARP cache search, request/reply generation and wait timeout, one transaction at a time.
// Depends on arpr_pkg for widths, command, kind and register codes.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser: cmd; s_tdata: parsed ARP fields
// m_        out        m_tvalid/m_tready  m_tuser: kind; m_tdata: peer_mac, peer_ip
// cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// A resolve reads one cache entry per cycle through the single compare unit in S_SRCH,
// then issues its result from S_OUT; packets and ticks are evaluated in S_EVAL and pass
// to S_OUT, or free the block straight from S_EVAL when they give no result.
// s_tready is high only in the idle state, entered as the result issues or as a packet
// or tick ends with none; a result waits in the output register while m_tready is low and the next one holds behind it.
// aresetn is synchronous, active low; cache contents are not cleared.
module arp_resolver_and_responder_top #(
    parameter int CACHE_DEPTH = arpr_pkg::DEFAULT_CACHE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [10:0] packet_length, [26:11] opcode, [74:27] sender_mac,
    // [106:75] sender_ip, [138:107] tgt_ip, [143:139] zero
    input  logic [arpr_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] cmd
    input  logic [arpr_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [47:0] peer_mac, [79:48] peer_ip
    output logic [arpr_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] kind
    output logic [arpr_pkg::KIND_W-1:0]       m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [arpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arpr_pkg::MAC_W-1:0]        cfg_wr_data
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_EVAL,
        S_OUT
    } state_t;

    state_t                          state_reg;
    logic [arpr_pkg::IP_W-1:0]       own_ip_reg;
    logic [arpr_pkg::MAC_W-1:0]      own_mac_reg;
    logic [arpr_pkg::TICK_W-1:0]     timeout_reg;

    logic [arpr_pkg::CMD_W-1:0]      cmd_reg;
    logic [arpr_pkg::LEN_W-1:0]      len_reg;
    logic [arpr_pkg::OP_W-1:0]       op_reg;
    logic [arpr_pkg::MAC_W-1:0]      smac_reg;
    logic [arpr_pkg::IP_W-1:0]       sip_reg;
    logic [arpr_pkg::IP_W-1:0]       tip_reg;

    logic [CNT_W-1:0]                entries_reg;
    logic [CNT_W-1:0]                idx_reg;
    logic                            rd_vld_reg;
    logic                            waiting_reg;
    logic [arpr_pkg::IP_W-1:0]       waited_ip_reg;
    logic [arpr_pkg::TICK_W-1:0]     ticks_reg;

    logic [arpr_pkg::KIND_W-1:0]     res_kind_reg;
    logic [arpr_pkg::MAC_W-1:0]      res_mac_reg;
    logic [arpr_pkg::IP_W-1:0]       res_ip_reg;

    logic                            m_valid_reg;
    logic [arpr_pkg::KIND_W-1:0]     m_kind_reg;
    logic [arpr_pkg::MAC_W-1:0]      m_mac_reg;
    logic [arpr_pkg::IP_W-1:0]       m_ip_reg;

    logic [arpr_pkg::IP_W-1:0]       cache_ip_mem  [CACHE_DEPTH];
    logic [arpr_pkg::MAC_W-1:0]      cache_mac_mem [CACHE_DEPTH];
    logic [arpr_pkg::IP_W-1:0]       rd_ip_reg;
    logic [arpr_pkg::MAC_W-1:0]      rd_mac_reg;

    logic [arpr_pkg::IP_W-1:0]       cmp_a;
    logic [arpr_pkg::IP_W-1:0]       cmp_b;
    logic                            cmp_eq;
    logic                            s_accept;
    logic                            srch_hit;
    logic                            rd_en;
    logic                            wr_en;
    logic [arpr_pkg::TICK_W-1:0]     ticks_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // shared equality unit: cache search, waited reply match, own-IP request match
    always_comb begin
        if (state_reg == S_SRCH) begin
            cmp_a = rd_ip_reg;
            cmp_b = tip_reg;
        end else if (waiting_reg) begin
            cmp_a = sip_reg;
            cmp_b = waited_ip_reg;
        end else begin
            cmp_a = tip_reg;
            cmp_b = own_ip_reg;
        end
    end
    assign cmp_eq = (cmp_a == cmp_b);

    assign srch_hit = (state_reg == S_SRCH) && rd_vld_reg && cmp_eq;
    assign rd_en    = (state_reg == S_SRCH) && !srch_hit && (idx_reg < entries_reg);
    assign wr_en    = (state_reg == S_EVAL) && (cmd_reg == arpr_pkg::CMD_PACKET)
                      && (len_reg >= arpr_pkg::ARP_MIN_LEN) && waiting_reg
                      && (op_reg == arpr_pkg::OP_REPLY) && cmp_eq
                      && (entries_reg < DEPTH_CNT);
    assign ticks_inc = (ticks_reg < arpr_pkg::TICKS_MAX) ? ticks_reg + 1'b1 : ticks_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cache_ip_mem[entries_reg[IDX_W-1:0]]  <= waited_ip_reg;
            cache_mac_mem[entries_reg[IDX_W-1:0]] <= smac_reg;
        end
        if (rd_en) begin
            rd_ip_reg  <= cache_ip_mem[idx_reg[IDX_W-1:0]];
            rd_mac_reg <= cache_mac_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
            timeout_reg <= arpr_pkg::TIMEOUT_RESET;
            entries_reg <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            waiting_reg <= 1'b0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    arpr_pkg::REG_OWN_IP:        own_ip_reg  <= cfg_wr_data[arpr_pkg::IP_W-1:0];
                    arpr_pkg::REG_OWN_MAC:       own_mac_reg <= cfg_wr_data;
                    arpr_pkg::REG_TIMEOUT_TICKS: timeout_reg <= cfg_wr_data[arpr_pkg::TICK_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        cmd_reg    <= s_tuser;
                        len_reg    <= s_tdata[10:0];
                        op_reg     <= s_tdata[26:11];
                        smac_reg   <= s_tdata[74:27];
                        sip_reg    <= s_tdata[106:75];
                        tip_reg    <= s_tdata[138:107];
                        idx_reg    <= '0;
                        rd_vld_reg <= 1'b0;
                        state_reg  <= (s_tuser == arpr_pkg::CMD_RESOLVE) ? S_SRCH : S_EVAL;
                    end
                end
                S_SRCH: begin
                    if (srch_hit) begin
                        waiting_reg  <= 1'b0;
                        ticks_reg    <= '0;
                        res_kind_reg <= arpr_pkg::KIND_RESOLVED;
                        res_mac_reg  <= rd_mac_reg;
                        res_ip_reg   <= tip_reg;
                        rd_vld_reg   <= 1'b0;
                        state_reg    <= S_OUT;
                    end else if (rd_en) begin
                        idx_reg    <= idx_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end else begin
                        waiting_reg   <= 1'b1;
                        waited_ip_reg <= tip_reg;
                        ticks_reg     <= '0;
                        res_kind_reg  <= arpr_pkg::KIND_REQUEST;
                        res_mac_reg   <= '0;
                        res_ip_reg    <= tip_reg;
                        rd_vld_reg    <= 1'b0;
                        state_reg     <= S_OUT;
                    end
                end
                S_EVAL: begin
                    case (cmd_reg)
                        arpr_pkg::CMD_PACKET: begin
                            if ((len_reg >= arpr_pkg::ARP_MIN_LEN) && waiting_reg
                                && (op_reg == arpr_pkg::OP_REPLY) && cmp_eq) begin
                                if (wr_en) begin
                                    entries_reg <= entries_reg + 1'b1;
                                end
                                waiting_reg  <= 1'b0;
                                ticks_reg    <= '0;
                                res_kind_reg <= arpr_pkg::KIND_RESOLVED;
                                res_mac_reg  <= smac_reg;
                                res_ip_reg   <= waited_ip_reg;
                                state_reg    <= S_OUT;
                            end else if ((len_reg >= arpr_pkg::ARP_MIN_LEN) && !waiting_reg
                                         && (op_reg == arpr_pkg::OP_REQUEST) && cmp_eq) begin
                                res_kind_reg <= arpr_pkg::KIND_REPLY;
                                res_mac_reg  <= smac_reg;
                                res_ip_reg   <= sip_reg;
                                state_reg    <= S_OUT;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                        arpr_pkg::CMD_TICK: begin
                            if (waiting_reg && (ticks_inc >= timeout_reg)) begin
                                waiting_reg  <= 1'b0;
                                ticks_reg    <= '0;
                                res_kind_reg <= arpr_pkg::KIND_FAILED;
                                res_mac_reg  <= '0;
                                res_ip_reg   <= waited_ip_reg;
                                state_reg    <= S_OUT;
                            end else begin
                                if (waiting_reg) begin
                                    ticks_reg <= ticks_inc;
                                end
                                state_reg <= S_IDLE;
                            end
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        m_mac_reg   <= res_mac_reg;
                        m_ip_reg    <= res_ip_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_ip_reg, m_mac_reg};

`ifndef NO_ASSERTIONS
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_reg <= DEPTH_CNT)
        else $error("cache fill count beyond depth");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= entries_reg)
        else $error("search index beyond filled entries");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("accepted a transaction while one is in progress");

    a_idle_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !waiting_reg |-> (ticks_reg == '0))
        else $error("tick count nonzero while not waiting");

    a_out_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result presented without a finished transaction");
`endif

endmodule

[tb/sv/arpr_action_check.sv]
// Result checker for arp_resolver_and_responder_top: predicts the ARP action of each
// accepted transaction and compares it with the result channel, field by field.
// Depends on arpr_pkg for widths, command, kind and register codes.
`timescale 1ns / 1ps
module arpr_action_check
    import arpr_pkg::*;
#(
    parameter int CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAC_W-1:0]     cfg_wr_data,
    output int unsigned          mismatch_count,
    output int unsigned          actions_due
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  peer_mac;
        logic [IP_W-1:0]   peer_ip;
    } arp_action_t;

    arp_action_t       action_queue[$];

    logic [IP_W-1:0]   own_ip;
    logic [MAC_W-1:0]  own_mac;
    logic [TICK_W-1:0] timeout_ticks;
    logic [IP_W-1:0]   cache_ip  [CACHE_DEPTH];
    logic [MAC_W-1:0]  cache_mac [CACHE_DEPTH];
    logic [3:0]        entries_used;
    logic              waiting;
    logic [IP_W-1:0]   waited_ip;
    logic [TICK_W-1:0] ticks_waited;

    function automatic bit arp_step(
        input  logic [CMD_W-1:0] cmd,
        input  logic [LEN_W-1:0] len,
        input  logic [OP_W-1:0]  op,
        input  logic [MAC_W-1:0] smac,
        input  logic [IP_W-1:0]  sip,
        input  logic [IP_W-1:0]  tip,
        output arp_action_t      act
    );
        act = '0;
        case (cmd)
            CMD_RESOLVE: begin
                for (int i = 0; i < CACHE_DEPTH; i++) begin
                    if (i < entries_used && cache_ip[i] == tip) begin
                        waiting      = 1'b0;
                        ticks_waited = '0;
                        act = '{KIND_RESOLVED, cache_mac[i], tip};
                        return 1'b1;
                    end
                end
                waiting      = 1'b1;
                waited_ip    = tip;
                ticks_waited = '0;
                act = '{KIND_REQUEST, '0, tip};
                return 1'b1;
            end
            CMD_PACKET: begin
                if (len < ARP_MIN_LEN)
                    return 1'b0;
                if (waiting) begin
                    if (op != OP_REPLY || sip != waited_ip)
                        return 1'b0;
                    if (entries_used < CACHE_DEPTH) begin
                        cache_ip[entries_used]  = waited_ip;
                        cache_mac[entries_used] = smac;
                        entries_used++;
                    end
                    waiting      = 1'b0;
                    ticks_waited = '0;
                    act = '{KIND_RESOLVED, smac, waited_ip};
                    return 1'b1;
                end
                if (op == OP_REQUEST && tip == own_ip) begin
                    act = '{KIND_REPLY, smac, sip};
                    return 1'b1;
                end
                return 1'b0;
            end
            CMD_TICK: begin
                if (!waiting)
                    return 1'b0;
                if (ticks_waited < TICKS_MAX)
                    ticks_waited++;
                if (ticks_waited >= timeout_ticks) begin
                    waiting      = 1'b0;
                    ticks_waited = '0;
                    act = '{KIND_FAILED, '0, waited_ip};
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
        if (mismatch_count < 100)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        arp_action_t got;
        arp_action_t want;
        arp_action_t act;
        if (!aresetn) begin
            own_ip        = '0;
            own_mac       = '0;
            timeout_ticks = TIMEOUT_RESET;
            entries_used  = '0;
            waiting       = 1'b0;
            ticks_waited  = '0;
            action_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_OWN_IP:        own_ip        = cfg_wr_data[IP_W-1:0];
                    REG_OWN_MAC:       own_mac       = cfg_wr_data;
                    REG_TIMEOUT_TICKS: timeout_ticks = cfg_wr_data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[MAC_W-1:0], m_tdata[MAC_W+IP_W-1:MAC_W]};
                if (action_queue.size() == 0) begin
                    if (mismatch_count < 100)
                        $display("%0t: unexpected result, expected none actual %h",
                                 $time, got);
                    mismatch_count++;
                end else begin
                    want = action_queue.pop_front();
                    if (got.kind != want.kind)
                        report("kind", 64'(want.kind), 64'(got.kind));
                    if (got.peer_mac != want.peer_mac)
                        report("peer_mac", 64'(want.peer_mac), 64'(got.peer_mac));
                    if (got.peer_ip != want.peer_ip)
                        report("peer_ip", 64'(want.peer_ip), 64'(got.peer_ip));
                end
            end
            if (s_tvalid && s_tready) begin
                if (arp_step(s_tuser, s_tdata[10:0], s_tdata[26:11], s_tdata[74:27],
                             s_tdata[106:75], s_tdata[138:107], act))
                    action_queue.push_back(act);
            end
        end
        actions_due = action_queue.size();
    end

endmodule

[tb/sv/arp_resolver_and_responder_top_tb.sv]
// Testbench top for arp_resolver_and_responder_top: drives resolves, ARP packets and
// ticks with bursty traffic and receiver stalls; arpr_action_check does the checking.
// Depends on arpr_pkg, arpr_action_check and the block under test.
`timescale 1ns / 1ps
module arp_resolver_and_responder_top_tb;
    import arpr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 130;
    localparam int POOL_SIZE   = 14;

    typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;
    logic [CMD_W-1:0]     s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [MAC_W-1:0]     cfg_wr_data = '0;

    int unsigned          mismatch_count;
    int unsigned          actions_due;
    int unsigned          quiet_cycles = 0;
    int unsigned          items_sent   = 0;
    int                   burst_left   = 1;
    logic [IP_W-1:0]      own_ip_now   = '0;
    logic [TICK_W-1:0]    timeout_now  = TIMEOUT_RESET;
    logic [IP_W-1:0]      ip_pool [POOL_SIZE];

    always #6 aclk = ~aclk;

    arp_resolver_and_responder_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    arpr_action_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .actions_due    (actions_due)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), $urandom};
    endfunction

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_arp(
        input logic [CMD_W-1:0] cmd,
        input logic [LEN_W-1:0] len,
        input logic [OP_W-1:0]  op,
        input logic [MAC_W-1:0] smac,
        input logic [IP_W-1:0]  sip,
        input logic [IP_W-1:0]  tip
    );
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, tip, sip, smac, op, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd != CMD_UNUSED && !(cmd == CMD_PACKET && len < ARP_MIN_LEN))
            items_sent++;
        pace();
    endtask

    task automatic send_resolve(input logic [IP_W-1:0] ip);
        send_arp(CMD_RESOLVE, 11'($urandom), 16'($urandom), rand_mac(), $urandom, ip);
    endtask

    task automatic send_reply(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        send_arp(CMD_PACKET, 11'($urandom_range(28, 1536)), OP_REPLY, mac, ip, $urandom);
    endtask

    task automatic send_tick();
        send_arp(CMD_TICK, 11'($urandom), 16'($urandom), rand_mac(), $urandom, $urandom);
    endtask

    // hold off input until every result is out and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (actions_due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic program_regs(
        input logic [IP_W-1:0]   ip,
        input logic [MAC_W-1:0]  mac,
        input logic [TICK_W-1:0] ticks
    );
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_OWN_IP;
        cfg_wr_data <= MAC_W'(ip);
        @(posedge aclk);
        cfg_index   <= REG_OWN_MAC;
        cfg_wr_data <= mac;
        @(posedge aclk);
        cfg_index   <= REG_TIMEOUT_TICKS;
        cfg_wr_data <= MAC_W'(ticks);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        own_ip_now  = ip;
        timeout_now = ticks;
    endtask

    task automatic run_scenario();
        int              pick;
        int              sub;
        int              n;
        logic [IP_W-1:0] ip;
        logic [IP_W-1:0] tip;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        ip   = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (pick < 35) begin
            send_resolve(ip);
            sub = $urandom_range(0, 9);
            if (sub == 5 || sub == 6) begin
                n = (timeout_now == 0) ? 1 : int'(timeout_now);
                if (n > 8 && $urandom_range(0, 3) != 0)
                    n = $urandom_range(1, n - 1);
                repeat (n) send_tick();
            end else if (sub == 7) begin
                send_reply(ip ^ (32'd1 << $urandom_range(0, 31)), rand_mac());
                send_reply(ip, rand_mac());
            end else if (sub == 8) begin
                send_arp(CMD_PACKET, 11'($urandom_range(28, 2047)), OP_REQUEST, rand_mac(),
                         $urandom, own_ip_now);
                send_reply(ip, rand_mac());
            end else if (sub != 9) begin
                repeat ($urandom_range(0, 2)) send_tick();
                send_reply(ip, rand_mac());
            end
        end else if (pick < 50) begin
            send_resolve(ip);
        end else if (pick < 70) begin
            tip = ($urandom_range(0, 4) == 0) ? ip : own_ip_now;
            op  = ($urandom_range(0, 5) == 0) ? 16'($urandom) : OP_REQUEST;
            send_arp(CMD_PACKET, 11'($urandom_range(28, 2047)), op, rand_mac(), $urandom, tip);
        end else if (pick < 78) begin
            send_tick();
        end else begin
            op  = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3));
            tip = $urandom_range(0, 1) ? ip : (($urandom_range(0, 1)) ? own_ip_now : $urandom);
            send_arp(2'($urandom_range(0, 3)),
                     $urandom_range(0, 2) ? 11'($urandom) : 11'($urandom_range(0, 40)),
                     op, rand_mac(), $urandom_range(0, 1) ? ip : $urandom, tip);
        end
    endtask

    // receiver: segments of stall patterns, plus two long hold-offs
    initial begin
        stall_mode_e mode;
        int          seg_len;
        int          k;
        int unsigned cyc;
        cyc = 0;
        forever begin
            mode    = stall_mode_e'($urandom_range(0, 3));
            seg_len = $urandom_range(16, 96);
            for (k = 0; k < seg_len; k++) begin
                case (mode)
                    STALL_NONE:  m_tready <= 1'b1;
                    STALL_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: m_tready <= ($urandom_range(0, 4) == 0);
                    default:     m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
                cyc++;
                if (cyc == 3000 || cyc == 7000) begin
                    m_tready <= 1'b0;
                    repeat (300) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        int phase;
        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        ip_pool[0] = '1;
        ip_pool[1] = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: own IP is zero
        send_arp(CMD_PACKET, 11'd28, OP_REQUEST, '1, '1, '0);
        send_arp(CMD_PACKET, 11'd27, OP_REQUEST, rand_mac(), $urandom, '0);
        send_tick();
        send_arp(CMD_UNUSED, '1, '1, '1, '1, '1);
        settle();
        program_regs(32'hC0A8_0101, 48'h0200_0000_0001, 6'd2);
        send_resolve('1);
        send_arp(CMD_PACKET, 11'h7FF, OP_REQUEST, rand_mac(), $urandom, own_ip_now);
        send_reply('0, rand_mac());
        send_arp(CMD_PACKET, 11'd0, OP_REPLY, rand_mac(), '1, $urandom);
        send_arp(CMD_PACKET, 11'd1536, OP_REPLY, '0, '1, '0);
        send_resolve('1);
        send_resolve('0);
        send_tick();
        send_tick();
        send_tick();
        send_resolve(32'h0A00_0001);
        send_resolve(32'h0A00_0002);
        send_reply(32'h0A00_0001, rand_mac());
        send_reply(32'h0A00_0002, '1);
        send_resolve('0);
        send_resolve('1);
        send_tick();
        send_arp(CMD_PACKET, 11'd64, 16'hFFFF, rand_mac(), $urandom, own_ip_now);
        send_arp(CMD_PACKET, 11'd60, OP_REQUEST, 48'hA5A5_5A5A_0F0F, 32'h0102_0304,
                 own_ip_now);
        settle();
        program_regs($urandom, rand_mac(), 6'd0);
        send_resolve(32'hDEAD_BEEF);
        send_tick();

        for (phase = 0; phase < 5; phase++) begin
            settle();
            case (phase)
                0:       program_regs($urandom, rand_mac(), 6'd1);
                1:       program_regs('1, '1, TICKS_MAX);
                2:       program_regs('0, '0, 6'($urandom_range(2, 8)));
                3:       program_regs($urandom, rand_mac(), 6'd0);
                default: program_regs($urandom, rand_mac(), TIMEOUT_RESET);
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS) run_scenario();
        end
        settle();

        if (mismatch_count == 0 && actions_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/arpr_pkg.sv
design/arp_resolver_and_responder_top.sv
tb/sv/arpr_action_check.sv
tb/sv/arp_resolver_and_responder_top_tb.sv
